### rtl/nmb_pkg.sv
// Shared types and constants for the 3x3 neighbour-mean blur.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nmb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int W_REG_W     = 11;
  localparam int H_REG_W     = 13;
  localparam int ROW_W       = 13;
  localparam int COUNT_W     = 22;
  localparam int PROD_W      = W_REG_W + H_REG_W;
  localparam int PIX_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = OFIFO_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [W_REG_W-1:0] RESET_WIDTH    = W_REG_W'(640);
  localparam logic [H_REG_W-1:0] RESET_HEIGHT   = H_REG_W'(480);
  localparam logic [COUNT_W-1:0] RESET_LAST_IDX = COUNT_W'(640 * 480 - 1);

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic              emit;
    logic              border;
    logic              last;
    logic              fwd;
    pixel_t            pix;
  } s1_item_t;

  typedef struct packed {
    pixel_t rgb;
    logic   frame_end;
  } result_t;

endpackage

`default_nettype wire

### rtl/neighbour_mean_blur_3x3.sv
// Streaming 3x3 neighbour-mean blur, RGB 8:8:8, two 1024-entry line buffers.
// One item per cycle unless pixel_stall; results go via the s1 register and queue.
// Output frame lags the input by frame_width + 1 items; a 4-deep queue absorbs stalls.
// After reset both line buffers are zeroed across all 1024 entries; pixel_stall is high then.
// Config writes are taken outside reset; width/height writes restart frame position.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_mean_blur_3x3
  import nmb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire logic                  action,
  input  wire logic [7:0]            red_in,
  input  wire logic [7:0]            green_in,
  input  wire logic [7:0]            blue_in,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic              accept;
  logic              clearing;
  logic              no_room;
  logic [ADDR_W-1:0] rd_addr;
  logic              s1_valid;
  s1_item_t          s1;
  pixel_t            mem_upper;
  pixel_t            mem_middle;
  pixel_t            wr_upper;
  pixel_t            wr_middle;
  logic              push;
  result_t           push_data;
  result_t           head;

  assign cfg_ready   = !rst;
  assign pixel_stall = rst || clearing || no_room;
  assign accept      = pixel_valid && !pixel_stall;

  nmb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .action    (action),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  nmb_linebuf u_linebuf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .wr_en     (s1_valid),
    .wr_addr   (s1.col),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle),
    .rd_upper  (mem_upper),
    .rd_middle (mem_middle),
    .clearing  (clearing)
  );

  nmb_window u_window (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .mem_upper  (mem_upper),
    .mem_middle (mem_middle),
    .wr_upper   (wr_upper),
    .wr_middle  (wr_middle),
    .push       (push),
    .push_data  (push_data)
  );

  nmb_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .in_flight (s1_valid),
    .pop       (result_valid && !result_stall),
    .not_empty (result_valid),
    .no_room   (no_room),
    .head      (head)
  );

  assign red_out   = head.rgb[23:16];
  assign green_out = head.rgb[15:8];
  assign blue_out  = head.rgb[7:0];
  assign frame_end = head.frame_end;

endmodule

`default_nettype wire

### rtl/nmb_linebuf.sv
// Two line buffers (row-2 and row-1), one read and one write port each.
// Runs a zeroing sweep after reset. Uses nmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmb_linebuf
  import nmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire pixel_t            wr_upper,
  input  wire pixel_t            wr_middle,
  output pixel_t                 rd_upper,
  output pixel_t                 rd_middle,
  output logic                   clearing
);

  pixel_t            upper_mem  [MAX_WIDTH];
  pixel_t            middle_mem [MAX_WIDTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pixel_t            mem_wupper;
  pixel_t            mem_wmiddle;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we      = clearing || wr_en;
    mem_waddr   = clearing ? clr_addr : wr_addr;
    mem_wupper  = clearing ? '0 : wr_upper;
    mem_wmiddle = clearing ? '0 : wr_middle;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[mem_waddr] <= mem_wupper;
    end
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      middle_mem[mem_waddr] <= mem_wmiddle;
    end
    if (rd_en) begin
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/nmb_seq.sv
// Frame registers, position counters and the read-stage item register.
// Decides emit, border and frame end per item. Uses nmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmb_seq
  import nmb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  accept,
  input  wire logic                  action,
  input  wire logic [7:0]            red_in,
  input  wire logic [7:0]            green_in,
  input  wire logic [7:0]            blue_in,
  output logic [ADDR_W-1:0]          rd_addr,
  output logic                       s1_valid,
  output s1_item_t                   s1
);

  logic [W_REG_W-1:0] w_eff;
  logic [H_REG_W-1:0] h_eff;
  logic [COUNT_W-1:0] last_idx;
  logic [ADDR_W-1:0]  in_column;
  logic [ROW_W-1:0]   in_row;
  logic [COUNT_W-1:0] out_count;

  logic [W_REG_W-1:0] w_sat;
  logic [H_REG_W-1:0] h_sat;
  logic [W_REG_W-1:0] w_next;
  logic [H_REG_W-1:0] h_next;
  logic [PROD_W-1:0]  prod;
  logic               reg_hit;
  logic [ADDR_W-1:0]  col;
  logic               col_last;
  s1_item_t           item;

  always_comb begin
    w_sat = cfg_data[W_REG_W-1:0];
    if (w_sat == '0) begin
      w_sat = W_REG_W'(1);
    end else if (w_sat > W_REG_W'(MAX_WIDTH)) begin
      w_sat = W_REG_W'(MAX_WIDTH);
    end
    h_sat = cfg_data[H_REG_W-1:0];
    if (h_sat == '0) begin
      h_sat = H_REG_W'(1);
    end else if (h_sat > H_REG_W'(MAX_HEIGHT)) begin
      h_sat = H_REG_W'(MAX_HEIGHT);
    end
    reg_hit = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);
    w_next  = (cfg_index == REG_FRAME_WIDTH) ? w_sat : w_eff;
    h_next  = (cfg_index == REG_FRAME_HEIGHT) ? h_sat : h_eff;
    prod    = PROD_W'(w_next) * PROD_W'(h_next);
  end

  always_comb begin
    col      = ({1'b0, in_column} >= w_eff) ? ADDR_W'(w_eff - W_REG_W'(1)) : in_column;
    col_last = ({1'b0, col} == (w_eff - W_REG_W'(1)));
    item.col    = col;
    item.emit   = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (col != '0));
    item.border = (col == '0) || (col == ADDR_W'(1)) || (in_row == ROW_W'(1)) ||
                  (in_row >= h_eff);
    item.last   = (out_count >= last_idx);
    item.fwd    = s1_valid && (s1.col == col);
    item.pix    = (action == ACT_DRAIN) ? '0 : {red_in, green_in, blue_in};
    rd_addr     = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff     <= RESET_WIDTH;
      h_eff     <= RESET_HEIGHT;
      last_idx  <= RESET_LAST_IDX;
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
    end else if (cfg_wr && reg_hit) begin
      w_eff     <= w_next;
      h_eff     <= h_next;
      last_idx  <= COUNT_W'(prod - PROD_W'(1));
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
    end else if (accept) begin
      if (item.emit && item.last) begin
        in_column <= '0;
        in_row    <= '0;
        out_count <= '0;
      end else begin
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + ROW_W'(1);
        end else begin
          in_column <= col + ADDR_W'(1);
        end
        if (item.emit) begin
          out_count <= out_count + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

endmodule

`default_nettype wire

### rtl/nmb_window.sv
// 3x3 window, line-buffer write-back with same-entry forwarding, and the
// neighbour-mean / pass-through result. Uses nmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmb_window
  import nmb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s1_valid,
  input  wire s1_item_t s1,
  input  wire pixel_t   mem_upper,
  input  wire pixel_t   mem_middle,
  output pixel_t        wr_upper,
  output pixel_t        wr_middle,
  output logic          push,
  output result_t       push_data
);

  pixel_t win   [3][3];
  pixel_t win_n [3][3];
  pixel_t last_mid;
  pixel_t last_pix;
  pixel_t top_eff;
  pixel_t mid_eff;
  logic [7:0] acc [3];

  always_comb begin
    top_eff = s1.fwd ? last_mid : mem_upper;
    mid_eff = s1.fwd ? last_pix : mem_middle;
    for (int r = 0; r < 3; r++) begin
      win_n[r][0] = win[r][1];
      win_n[r][1] = win[r][2];
    end
    win_n[0][2] = top_eff;
    win_n[1][2] = mid_eff;
    win_n[2][2] = s1.pix;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          if (!(r == 1 && j == 1)) begin
            acc[ch] = acc[ch] + (win_n[r][j][8*ch +: 8] >> 3);
          end
        end
      end
    end
    wr_upper  = mid_eff;
    wr_middle = s1.pix;
    push      = s1_valid && s1.emit;
    push_data.frame_end = s1.last;
    push_data.rgb = s1.border ? win_n[1][1] : {acc[2], acc[1], acc[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          win[r][j] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          win[r][j] <= win_n[r][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      last_mid <= mid_eff;
      last_pix <= s1.pix;
    end
  end

endmodule

`default_nettype wire

### rtl/nmb_ofifo.sv
// Small result queue between the datapath and the output channel.
// Reports full when in-flight items could overrun it. Uses nmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmb_ofifo
  import nmb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    in_flight,
  input  wire logic    pop,
  output logic         not_empty,
  output logic         no_room,
  output result_t      head
);

  result_t                slots [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr;
  logic [OFIFO_PTR_W-1:0] rd_ptr;
  logic [OFIFO_CNT_W-1:0] count;

  always_comb begin
    not_empty = (count != '0);
    no_room   = ((count + OFIFO_CNT_W'(in_flight)) >= OFIFO_CNT_W'(OFIFO_DEPTH));
    head      = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OFIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OFIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OFIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OFIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for neighbour_mean_blur_3x3: streams RGB frames and drain items
// through the block and checks every blurred pixel against an in-bench line-buffer model.
// Depends on nmb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import nmb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS   = 30;
  localparam logic        ACT_PIXEL      = ~ACT_DRAIN;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  action = ACT_PIXEL;
  logic [7:0]            red_in = '0;
  logic [7:0]            green_in = '0;
  logic [7:0]            blue_in = '0;
  logic                  result_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_stall;
  logic                  result_valid;
  logic [7:0]            red_out;
  logic [7:0]            green_out;
  logic [7:0]            blue_out;
  logic                  frame_end;
  logic                  cfg_ready;

  neighbour_mean_blur_3x3 i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .action       (action),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [W_REG_W-1:0] width_reg;
  logic [H_REG_W-1:0] height_reg;
  pixel_t             upper_line [MAX_WIDTH];
  pixel_t             middle_line [MAX_WIDTH];
  pixel_t             win [9];
  int unsigned        in_col;
  int unsigned        in_row;
  int unsigned        out_cnt;
  result_t            blurred_q[$];

  int unsigned send_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned drains_sent;
  int unsigned reg_writes;
  int unsigned pixels_checked;
  int unsigned frames_closed;
  result_t     got_px;
  result_t     want_px;

  function automatic int unsigned pick_idle(input int unsigned pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(4, 1);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = pixel_t'($urandom);
    case ($urandom_range(7))
      0: px = '0;
      1: px = '1;
      default: ;
    endcase
    return px;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  // eight neighbours, each truncated to an eighth; the centre is skipped
  function automatic logic [7:0] neighbour_mean(input int unsigned sh);
    logic [10:0] acc;
    acc = '0;
    for (int i = 0; i < 9; i++)
      if (i != 4) acc += 11'(win[i][sh +: 8] >> 3);
    return acc[7:0];
  endfunction

  task automatic restart_position();
    in_col  = 0;
    in_row  = 0;
    out_cnt = 0;
  endtask

  task automatic predict_blurred_pixel(input logic act, input pixel_t px_in);
    int unsigned w, h, col, row;
    pixel_t      px, top, mid;
    logic        show, border, last;
    result_t     res;
    w   = eff_width();
    h   = eff_height();
    col = in_col;
    row = in_row;
    if (col >= w) col = w - 1;
    px  = (act == ACT_DRAIN) ? '0 : px_in;
    top = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    show = (row >= 2) || (row == 1 && col >= 1);
    if (col + 1 >= w) begin
      in_col = 0;
      in_row = (row + 1) & 32'h1fff;
    end else begin
      in_col = col + 1;
    end
    if (show) begin
      if (col == 0) begin
        border = 1'b1;
      end else begin
        border = (row - 1 == 0) || (row - 1 >= h - 1) || (col - 1 == 0) || (col - 1 >= w - 1);
      end
      if (border) res.rgb = win[4];
      else res.rgb = {neighbour_mean(16), neighbour_mean(8), neighbour_mean(0)};
      last = (out_cnt >= w * h - 1);
      res.frame_end = last;
      blurred_q.push_back(res);
      if (last) restart_position();
      else out_cnt++;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= 30) $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_item(input logic act, input pixel_t px);
    int unsigned gap;
    gap = pick_idle(send_pct);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    action      <= act;
    red_in      <= px[23:16];
    green_in    <= px[15:8];
    blue_in     <= px[7:0];
    do @(posedge clk); while (pixel_stall);
    predict_blurred_pixel(act, px);
    items_sent++;
    if (act == ACT_DRAIN) drains_sent++;
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val[W_REG_W-1:0];
      restart_position();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val[H_REG_W-1:0];
      restart_position();
    end
    @(posedge clk);
  endtask

  task automatic send_clean_frame();
    int unsigned w, h;
    w = eff_width();
    h = eff_height();
    repeat (w * h) send_item(ACT_PIXEL, rand_pixel());
    repeat (w + 1) send_item(ACT_DRAIN, rand_pixel());
  endtask

  // reset geometry is 640 wide: first output only after 641 items
  task automatic test_reset_geometry();
    send_pct  = 10;
    stall_pct = 10;
    repeat (643) send_item(ACT_PIXEL, rand_pixel());
    wait_idle();
  endtask

  task automatic test_small_frames();
    pixel_t pix [9];
    pix = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
            24'hFF807F, 24'hFFFFFF, 24'h55AA01, 24'hFFFFFF};
    send_pct  = 30;
    stall_pct = 30;
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    foreach (pix[i]) send_item(ACT_PIXEL, pix[i]);
    send_item(ACT_DRAIN, 24'hFFFFFF);
    send_item(ACT_DRAIN, 24'h000000);
    send_item(ACT_PIXEL, 24'h123456);   // pixel in a drain slot
    send_item(ACT_DRAIN, 24'hAAAAAA);
    // second frame with drains inside it
    send_item(ACT_PIXEL, 24'hFFFFFF);
    send_item(ACT_DRAIN, 24'h555555);
    send_item(ACT_PIXEL, 24'h808080);
    send_item(ACT_PIXEL, 24'hFFFFFF);
    send_item(ACT_DRAIN, 24'hFFFFFF);
    send_item(ACT_PIXEL, 24'h7F7F7F);
    send_item(ACT_PIXEL, 24'h010203);
    send_item(ACT_PIXEL, 24'hFEFDFC);
    send_item(ACT_PIXEL, 24'h000000);
    repeat (4) send_item(ACT_DRAIN, 24'h000000);
    wait_idle();
  endtask

  task automatic test_register_limits();
    send_pct  = 20;
    stall_pct = 20;
    // 2048 masks to zero width, zero height: both saturate to one
    write_reg(REG_FRAME_WIDTH, 13'h0800);
    write_reg(REG_FRAME_HEIGHT, 13'h0000);
    send_item(ACT_PIXEL, 24'hC3A5F0);
    repeat (2) send_item(ACT_DRAIN, 24'h000000);
    wait_idle();
    // oversized height, partial stream then restart
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    repeat (12) send_item(1'($urandom_range(1)), rand_pixel());
    wait_idle();
    // unmapped indexes must leave the frame position alone
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    repeat (3) send_item(ACT_PIXEL, rand_pixel());
    wait_idle();
    write_reg(REG_UNMAPPED_LO, 13'h1FFF);
    write_reg(REG_UNMAPPED_HI, 13'h0AAA);
    send_item(ACT_PIXEL, rand_pixel());
    repeat (3) send_item(ACT_DRAIN, rand_pixel());
    wait_idle();
  endtask

  // widest rows saturate to 1024: a short burst stays inside warm-up
  task automatic test_wide_rows();
    send_pct  = 3;
    stall_pct = 3;
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    repeat (8) send_item(ACT_PIXEL, rand_pixel());
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, n, pct;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(6, 1);
        7, 8: w = $urandom_range(12, 7);
        default: w = $urandom_range(20, 13);
      endcase
      h = ($urandom_range(4) == 0) ? $urandom_range(8, 1) : $urandom_range(4, 1);
      case ($urandom_range(2))
        0: pct = 0;
        1: pct = 15;
        default: pct = 50;
      endcase
      wait_idle();
      send_pct  = pct;
      stall_pct = ($urandom_range(3) == 0) ? 0 : pct + 10;
      write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
      if ($urandom_range(5) == 0)
        write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
      repeat ($urandom_range(2, 1)) begin
        if (items_sent - start < RANDOM_ITEMS) begin
          if ($urandom_range(4) != 0) begin
            send_clean_frame();
          end else begin
            n = $urandom_range(w * h + 2 * w + 2, 1);
            repeat (n) send_item(1'($urandom_range(1)), rand_pixel());
          end
        end
      end
    end
    wait_idle();
  endtask

  always @(posedge clk) begin : stall_gen
    int unsigned len;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      len = pick_idle(stall_pct);
      result_stall <= (len != 0);
      stall_left   <= (len != 0) ? len - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (blurred_q.size() == 0) begin
        report_mismatch("unexpected item", {red_out, green_out, blue_out}, 0);
      end else begin
        want_px = blurred_q.pop_front();
        got_px  = '{rgb: {red_out, green_out, blue_out}, frame_end: frame_end};
        if (got_px.rgb[23:16] != want_px.rgb[23:16])
          report_mismatch("red", got_px.rgb[23:16], want_px.rgb[23:16]);
        if (got_px.rgb[15:8] != want_px.rgb[15:8])
          report_mismatch("green", got_px.rgb[15:8], want_px.rgb[15:8]);
        if (got_px.rgb[7:0] != want_px.rgb[7:0])
          report_mismatch("blue", got_px.rgb[7:0], want_px.rgb[7:0]);
        if (got_px.frame_end != want_px.frame_end)
          report_mismatch("frame_end", got_px.frame_end, want_px.frame_end);
        pixels_checked++;
        if (frame_end) frames_closed++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (middle_line[i]) middle_line[i] = '0;
    foreach (win[i]) win[i] = '0;
    restart_position();
    send_pct       = 0;
    stall_pct      = 0;
    idle_cycles    = 0;
    err_count      = 0;
    items_sent     = 0;
    drains_sent    = 0;
    reg_writes     = 0;
    pixels_checked = 0;
    frames_closed  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_small_frames();
    test_register_limits();
    test_wide_rows();
    test_random_frames();
    wait_idle();
    if (blurred_q.size() != 0) report_mismatch("missing items", 0, blurred_q.size());
    $display("sent %0d items (%0d drains) over %0d register writes", items_sent, drains_sent,
             reg_writes);
    $display("checked %0d blurred pixels, %0d frame ends, %0d mismatches", pixels_checked,
             frames_closed, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
